>>> src/progressive_pixel_accumulator_core_defines.svh
`ifndef PROGRESSIVE_PIXEL_ACCUMULATOR_CORE_DEFINES_SVH
`define PROGRESSIVE_PIXEL_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PPA_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PPA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/ppa_pkg.sv
package ppa_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int COUNT_BITS = 24;

	localparam int PIXELS    = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS = $clog2(PIXELS);

	localparam int COORD_BITS    = 9;
	localparam int DIM_BITS      = 10;
	localparam int IDX_FULL_BITS = COORD_BITS + DIM_BITS;
	localparam int MEAN_BITS     = 32;
	localparam int LANES         = 3;
	localparam int NUM_BITS      = MEAN_BITS + COUNT_BITS;
	localparam int DIV_BITS      = COUNT_BITS + 1;
	localparam int RADIX_BITS    = 4;
	localparam int DIV_STEPS     = MEAN_BITS / RADIX_BITS;
	localparam int STEP_BITS     = $clog2(DIV_STEPS);

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(512);
	localparam logic [DIM_BITS-1:0] WIDTH_LIM = DIM_BITS'(MAX_WIDTH);
	localparam logic [DIM_BITS-1:0] HEIGHT_LIM = DIM_BITS'(MAX_HEIGHT);
	localparam logic [ADDR_BITS-1:0] ADDR_LAST = ADDR_BITS'(PIXELS - 1);

	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef logic [LANES-1:0][MEAN_BITS-1:0] mean_t;
	typedef logic [LANES-1:0][NUM_BITS-1:0]  num_arr_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

>>> src/progressive_pixel_accumulator_core.sv
// channel  direction  handshake            beat
// in       input      in_valid/in_ready    opcode, pixel_x, pixel_y, samples, sample_invalid
// out      output     out_valid/out_ready  accepted, sample_total, mean_red/green/blue
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item at a time; read, reject and first sample pass through the address, load and done states
// accumulate into a nonzero count also waits on the radix-16 divider between load and done
// count and mean live in single-port-write rams with registered read
// after reset a clearing pass zeroes the count ram, no input taken
// the result register frees the input side; a stalled output holds the write back and the input side
`include "progressive_pixel_accumulator_core_defines.svh"

module progressive_pixel_accumulator_core
	import ppa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic [MEAN_BITS-1:0]  sample_red,
	input  logic [MEAN_BITS-1:0]  sample_green,
	input  logic [MEAN_BITS-1:0]  sample_blue,
	input  logic                  sample_invalid,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  accepted,
	output logic [COUNT_BITS-1:0] sample_total,
	output logic [MEAN_BITS-1:0]  mean_red,
	output logic [MEAN_BITS-1:0]  mean_green,
	output logic [MEAN_BITS-1:0]  mean_blue,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [DIM_BITS-1:0]   cfg_data
);

	state_t state_q;
	state_t state_d;

	logic [ADDR_BITS-1:0] clr_addr_q;
	logic [DIM_BITS-1:0]  width_q;
	logic [DIM_BITS-1:0]  height_q;
	logic [DIM_BITS-1:0]  w_eff;
	logic [DIM_BITS-1:0]  h_eff;

	logic                  op_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	mean_t                 smp_q;
	logic                  inv_q;
	logic [ADDR_BITS-1:0]  idx_q;
	logic                  rej_q;
	logic [COUNT_BITS-1:0] cnt_q;
	mean_t                 new_mean_q;

	logic [IDX_FULL_BITS-1:0] idx_full;
	logic                     rej_cmb;
	logic [COUNT_BITS-1:0]    cnt_inc;
	logic [COUNT_BITS-1:0]    total_new;

	logic                  cnt_we;
	logic [ADDR_BITS-1:0]  cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic                  mean_we;
	mean_t                 mean_rd;
	logic                  rd_en;

	div_req_t div_req;
	div_rsp_t div_rsp;
	num_arr_t num_cmb;
	mean_t    quo;

	logic                  out_load;
	logic                  out_valid_q;
	logic                  accepted_q;
	logic [COUNT_BITS-1:0] total_q;
	mean_t                 res_mean_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	assign w_eff = (width_q > WIDTH_LIM) ? WIDTH_LIM : width_q;
	assign h_eff = (height_q > HEIGHT_LIM) ? HEIGHT_LIM : height_q;

	// address and rejection
	assign idx_full = IDX_FULL_BITS'(y_q) * IDX_FULL_BITS'(w_eff) + IDX_FULL_BITS'(x_q);
	assign rej_cmb  = ({1'b0, x_q} >= w_eff) || ({1'b0, y_q} >= h_eff)
		|| (op_q == OP_ACCUM && inv_q);

	assign cnt_inc   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign total_new = (op_q == OP_ACCUM) ? cnt_inc : cnt_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			num_cmb[l] = NUM_BITS'(cnt_rd) * NUM_BITS'(mean_rd[l]) + NUM_BITS'(smp_q[l]);
		end
	end

	// control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		cnt_we    = 1'b0;
		mean_we   = 1'b0;
		cnt_waddr = idx_q;
		cnt_wdata = cnt_inc;
		out_load  = 1'b0;
		div_req   = '{start: 1'b0, divisor: DIV_BITS'(cnt_rd) + 1'b1};
		unique case (state_q)
			ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_addr_q;
				cnt_wdata = '0;
				if (clr_addr_q == ADDR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				rd_en   = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!rej_q && op_q == OP_ACCUM && cnt_rd != '0) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (!rej_q && op_q == OP_ACCUM) begin
						cnt_we  = 1'b1;
						mean_we = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q          <= opcode;
			x_q           <= pixel_x;
			y_q           <= pixel_y;
			smp_q[CH_RED]   <= sample_red;
			smp_q[CH_GREEN] <= sample_green;
			smp_q[CH_BLUE]  <= sample_blue;
			inv_q         <= sample_invalid;
		end
		if (state_q == ST_ADDR) begin
			idx_q <= idx_full[ADDR_BITS-1:0];
			rej_q <= rej_cmb;
		end
		if (state_q == ST_LOAD) begin
			cnt_q <= cnt_rd;
			if (op_q == OP_READ) begin
				new_mean_q <= (cnt_rd == '0) ? '0 : mean_rd;
			end else begin
				new_mean_q <= smp_q;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			new_mean_q <= quo;
		end
		if (out_load) begin
			accepted_q <= !rej_q;
			total_q    <= rej_q ? '0 : total_new;
			res_mean_q <= rej_q ? '0 : new_mean_q;
		end
	end

	ppa_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(PIXELS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (rd_en),
		.raddr(idx_full[ADDR_BITS-1:0]),
		.rdata(cnt_rd)
	);

	ppa_ram #(
		.WIDTH(LANES * MEAN_BITS),
		.DEPTH(PIXELS)
	) u_mean_ram (
		.clk  (clk),
		.we   (mean_we),
		.waddr(idx_q),
		.wdata(new_mean_q),
		.re   (rd_en),
		.raddr(idx_full[ADDR_BITS-1:0]),
		.rdata(mean_rd)
	);

	ppa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.num   (num_cmb),
		.rsp   (div_rsp),
		.quo   (quo)
	);

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign sample_total = total_q;
	assign mean_red     = res_mean_q[CH_RED];
	assign mean_green   = res_mean_q[CH_GREEN];
	assign mean_blue    = res_mean_q[CH_BLUE];

	`PPA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second beat taken while busy")
	`PPA_ASSERT_IMPL(a_div_alive, state_q == ST_DIV, div_rsp.busy || div_rsp.done, "divider idle while waited on")
	`PPA_ASSERT_IMPL(a_reject_zero, out_valid && !accepted, sample_total == '0 && mean_red == '0 && mean_green == '0 && mean_blue == '0, "rejected result not zero")
	`PPA_ASSERT_IMPL(a_count_nonzero, cnt_we && state_q != ST_CLEAR, cnt_wdata != '0, "count write back of zero")

endmodule

>>> src/ppa_ram.sv
module ppa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/ppa_div.sv
module ppa_div
	import ppa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	input  num_arr_t num,
	output div_rsp_t rsp,
	output mean_t    quo
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_BITS-1:0] step_q;
	logic [DIV_BITS-1:0] d_q;
	logic [LANES-1:0][DIV_BITS-1:0] rem_q;
	logic [LANES-1:0][DIV_BITS-1:0] rem_nx;
	mean_t low_q;
	mean_t low_nx;

	// radix-16 restoring step, one quotient digit per cycle on each lane
	always_comb begin
		logic [DIV_BITS-1:0]  r;
		logic [MEAN_BITS-1:0] q;
		logic [DIV_BITS:0]    t;
		for (int l = 0; l < LANES; l++) begin
			r = rem_q[l];
			q = low_q[l];
			for (int j = 0; j < RADIX_BITS; j++) begin
				t = {r, q[MEAN_BITS-1]};
				q = {q[MEAN_BITS-2:0], 1'b0};
				if (t >= {1'b0, d_q}) begin
					t    = t - {1'b0, d_q};
					q[0] = 1'b1;
				end
				r = t[DIV_BITS-1:0];
			end
			rem_nx[l] = r;
			low_nx[l] = q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (step_q == STEP_BITS'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q <= req.divisor;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= {1'b0, num[l][NUM_BITS-1:MEAN_BITS]};
				low_q[l] <= num[l][MEAN_BITS-1:0];
			end
		end else if (busy_q) begin
			rem_q <= rem_nx;
			low_q <= low_nx;
		end
	end

	assign rsp = '{busy: busy_q, done: done_q};
	assign quo = low_q;

endmodule

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ppa_pkg::*;

	typedef struct packed {
		logic                  op;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		mean_t                 sample;
		logic                  invalid;
	} pixel_item_t;

	typedef struct packed {
		logic                  accepted;
		logic [COUNT_BITS-1:0] total;
		mean_t                 mean;
	} pixel_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  out_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_index = CFG_IMAGE_WIDTH;
	logic [DIM_BITS-1:0]   cfg_data  = '0;
	pixel_item_t           cur_item  = '0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  cfg_ready;
	logic                  accepted;
	logic [COUNT_BITS-1:0] sample_total;
	logic [MEAN_BITS-1:0]  mean_red;
	logic [MEAN_BITS-1:0]  mean_green;
	logic [MEAN_BITS-1:0]  mean_blue;

	pixel_item_t   queued_samples [$];
	pixel_result_t expected_means [$];
	logic [COUNT_BITS-1:0] count_mem [int];
	mean_t                 mean_mem  [int];
	logic [DIM_BITS-1:0]   img_width  = DIM_RESET;
	logic [DIM_BITS-1:0]   img_height = DIM_RESET;

	int in_gap     = 0;
	int out_stall  = 0;
	bit steady_in  = 1'b0;
	bit steady_out = 1'b0;
	int mismatches = 0;

	progressive_pixel_accumulator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (cur_item.op),
		.pixel_x       (cur_item.x),
		.pixel_y       (cur_item.y),
		.sample_red    (cur_item.sample[CH_RED]),
		.sample_green  (cur_item.sample[CH_GREEN]),
		.sample_blue   (cur_item.sample[CH_BLUE]),
		.sample_invalid(cur_item.invalid),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.accepted      (accepted),
		.sample_total  (sample_total),
		.mean_red      (mean_red),
		.mean_green    (mean_green),
		.mean_blue     (mean_blue),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("status: fail");
		$finish;
	end

	function automatic int dim_limit(logic [DIM_BITS-1:0] v, int lim);
		return (int'(v) > lim) ? lim : int'(v);
	endfunction

	// folds an accepted accumulate beat into the pixel store and returns the result any beat should produce
	function automatic pixel_result_t fold_sample(pixel_item_t it);
		pixel_result_t         r;
		int                    w;
		int                    h;
		int                    idx;
		logic [COUNT_BITS-1:0] n;
		mean_t                 m;
		longint unsigned       num;
		r = '0;
		w = dim_limit(img_width, MAX_WIDTH);
		h = dim_limit(img_height, MAX_HEIGHT);
		if (int'(it.x) >= w || int'(it.y) >= h)
			return r;
		if (it.op == OP_ACCUM && it.invalid)
			return r;
		idx = int'(it.y) * w + int'(it.x);
		n = count_mem.exists(idx) ? count_mem[idx] : '0;
		m = mean_mem.exists(idx) ? mean_mem[idx] : '0;
		if (it.op == OP_ACCUM) begin
			for (int c = 0; c < LANES; c++) begin
				if (n == '0) begin
					m[c] = it.sample[c];
				end else begin
					num = m[c];
					num = num * n + it.sample[c];
					m[c] = MEAN_BITS'(num / (64'(n) + 64'd1));
				end
			end
			if (n != COUNT_MAX)
				n = n + 1'b1;
			count_mem[idx] = n;
			mean_mem[idx] = m;
		end
		r.accepted = 1'b1;
		r.total = n;
		if (n != '0)
			r.mean = m;
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord(int lim);
		if (lim == 0)
			return COORD_BITS'($urandom_range(0, 511));
		case ($urandom_range(0, 9))
			0: return COORD_BITS'($urandom_range(0, 511));
			1: return COORD_BITS'(lim - 1);
			default: return COORD_BITS'($urandom_range(0, ((lim < 6) ? lim : 6) - 1));
		endcase
	endfunction

	function automatic logic [MEAN_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return MEAN_BITS'($urandom_range(0, 65535));
			default: return MEAN_BITS'($urandom);
		endcase
	endfunction

	function automatic pixel_item_t random_item();
		pixel_item_t it;
		it.op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ACCUM;
		it.x = pick_coord(dim_limit(img_width, MAX_WIDTH));
		it.y = pick_coord(dim_limit(img_height, MAX_HEIGHT));
		it.invalid = ($urandom_range(0, 15) == 0);
		for (int c = 0; c < LANES; c++)
			it.sample[c] = pick_sample();
		return it;
	endfunction

	task automatic queue_item(logic op, int x, int y, logic [MEAN_BITS-1:0] r,
			logic [MEAN_BITS-1:0] g, logic [MEAN_BITS-1:0] b, logic inv);
		pixel_item_t it;
		it.op = op;
		it.x = COORD_BITS'(x);
		it.y = COORD_BITS'(y);
		it.sample[CH_RED] = r;
		it.sample[CH_GREEN] = g;
		it.sample[CH_BLUE] = b;
		it.invalid = inv;
		queued_samples = {queued_samples, it};
	endtask

	task automatic write_reg(logic idx, logic [DIM_BITS-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH)
			img_width = value;
		else
			img_height = value;
	endtask

	// checked at the falling edge, once the driver and monitor updates have settled
	task automatic drain();
		while (queued_samples.size() != 0 || in_valid || expected_means.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_image(int w, int h);
		drain();
		write_reg(CFG_IMAGE_WIDTH, DIM_BITS'(w));
		write_reg(CFG_IMAGE_HEIGHT, DIM_BITS'(h));
	endtask

	task automatic random_run(int w, int h, int count);
		set_image(w, h);
		for (int i = 0; i < count; i++)
			queued_samples = {queued_samples, random_item()};
	endtask

	task automatic note_mismatch(string what, pixel_result_t want, pixel_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: exp acc=%0b n=%0d rgb=%h/%h/%h got acc=%0b n=%0d rgb=%h/%h/%h",
				what, want.accepted, want.total, want.mean[CH_RED], want.mean[CH_GREEN],
				want.mean[CH_BLUE], got.accepted, got.total, got.mean[CH_RED],
				got.mean[CH_GREEN], got.mean[CH_BLUE]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_means = {expected_means, fold_sample(cur_item)};
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (queued_samples.size() != 0) begin
					cur_item <= queued_samples.pop_front();
					in_valid <= 1'b1;
					in_gap <= steady_in ? 0 : $urandom_range(0, 5);
					if ($urandom_range(0, 19) == 0)
						steady_in <= !steady_in;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_check
		int            stall;
		pixel_result_t want;
		pixel_result_t got;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			stall = out_stall;
			if (out_valid && out_ready) begin
				got.accepted = accepted;
				got.total = sample_total;
				got.mean[CH_RED] = mean_red;
				got.mean[CH_GREEN] = mean_green;
				got.mean[CH_BLUE] = mean_blue;
				if (expected_means.size() == 0) begin
					note_mismatch("unexpected beat", '0, got);
				end else begin
					want = expected_means.pop_front();
					if (got.accepted !== want.accepted || got.total !== want.total
							|| got.mean[CH_RED] !== want.mean[CH_RED]
							|| got.mean[CH_GREEN] !== want.mean[CH_GREEN]
							|| got.mean[CH_BLUE] !== want.mean[CH_BLUE])
						note_mismatch("mismatch", want, got);
				end
				stall = steady_out ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 19) == 0)
					steady_out <= !steady_out;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				out_stall <= stall - 1;
			end else begin
				out_ready <= 1'b1;
				out_stall <= 0;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// default 512 x 512 image
		queue_item(OP_READ, 0, 0, '0, '0, '0, 1'b0);
		queue_item(OP_ACCUM, 0, 0, '1, '1, '1, 1'b0);
		queue_item(OP_ACCUM, 0, 0, '0, '0, '0, 1'b0);
		queue_item(OP_ACCUM, 0, 0, '1, 32'h0001_0000, 32'h8000_0001, 1'b0);
		queue_item(OP_READ, 0, 0, '1, '1, '1, 1'b1);
		queue_item(OP_ACCUM, 511, 511, 32'h1234_5678, '1, '0, 1'b1);
		queue_item(OP_ACCUM, 511, 511, 32'hAAAA_AAAA, 32'h5555_5555, '1, 1'b0);
		queue_item(OP_ACCUM, 511, 511, 32'h5555_5555, 32'hAAAA_AAAA, '0, 1'b0);
		queue_item(OP_READ, 511, 511, '1, '1, '1, 1'b1);
		queue_item(OP_READ, 511, 0, '0, '0, '0, 1'b0);
		queue_item(OP_READ, 0, 511, '0, '0, '0, 1'b0);

		// oversized width clamps to the maximum, single row
		set_image(1023, 1);
		queue_item(OP_ACCUM, 5, 0, 32'hDEAD_BEEF, 32'h0000_0001, '1, 1'b0);
		queue_item(OP_ACCUM, 5, 1, 32'hDEAD_BEEF, '0, '0, 1'b0);
		queue_item(OP_READ, 5, 0, '0, '0, '0, 1'b0);

		// zero dimensions reject everything
		set_image(0, 512);
		queue_item(OP_ACCUM, 0, 0, '1, '1, '1, 1'b0);
		queue_item(OP_READ, 0, 0, '0, '0, '0, 1'b0);
		set_image(512, 0);
		queue_item(OP_ACCUM, 0, 0, '1, '1, '1, 1'b0);
		queue_item(OP_READ, 0, 0, '0, '0, '0, 1'b0);

		// single pixel image
		set_image(1, 1);
		queue_item(OP_ACCUM, 0, 0, 32'h0000_0003, '1, '0, 1'b0);
		queue_item(OP_READ, 1, 0, '0, '0, '0, 1'b0);
		queue_item(OP_READ, 0, 1, '0, '0, '0, 1'b0);
		queue_item(OP_READ, 0, 0, '0, '0, '0, 1'b0);

		random_run(6, 5, 250);
		random_run(512, 512, 250);
		random_run(1, 512, 100);
		random_run(1023, 3, 150);
		random_run(37, 1023, 150);
		random_run(3, 2, 100);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_means.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
